>>> hw/rtl/blocked_bloom_filter_top_defines.svh
// assertion macros shared by the blocked bloom filter rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef BLOCKED_BLOOM_FILTER_TOP_DEFINES_SVH
`define BLOCKED_BLOOM_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blocked bloom filter check failed");
`define BBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blocked bloom filter check failed");
`else
`define BBF_ASSERT_IMP(lbl, ante, cons)
`define BBF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/bbf_pkg.sv
// types and constants of the blocked bloom filter
// used by bbf_regs, bbf_ctrl, bbf_dp and blocked_bloom_filter_top
package bbf_pkg;

    localparam int BLOCK_BITS = 512;
    localparam int POS_W      = 9;
    localparam int HALF_W     = 32;
    localparam int SCALE_W    = 11;
    localparam int PROD_W     = HALF_W + SCALE_W;
    localparam int LANES      = 8;
    localparam int CNT_W      = 8;
    localparam int NH_W       = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    localparam logic REG_NUM_HASHES    = 1'b0;
    localparam logic REG_ACTIVE_BLOCKS = 1'b1;

    localparam logic [NH_W-1:0]    NUM_HASHES_RST    = 7'd1;
    localparam logic [SCALE_W-1:0] ACTIVE_BLOCKS_RST = 11'd1024;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic index_en;
        logic mask_step;
        logic apply_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic mask_done;
        logic kind_check;
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/bbf_regs.sv
// apb configuration registers: num_hashes and active_blocks
// depends on bbf_pkg
module bbf_regs
    import bbf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [NH_W-1:0]    o_num_hashes,
    output logic [SCALE_W-1:0] o_active_blocks
);

    logic [NH_W-1:0]    r_num_hashes;
    logic [SCALE_W-1:0] r_active_blocks;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_hashes    <= NUM_HASHES_RST;
            r_active_blocks <= ACTIVE_BLOCKS_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_NUM_HASHES:    r_num_hashes    <= pwdata[NH_W-1:0];
                REG_ACTIVE_BLOCKS: r_active_blocks <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_HASHES:    prdata = 32'(r_num_hashes);
            REG_ACTIVE_BLOCKS: prdata = 32'(r_active_blocks);
            default:           prdata = '0;
        endcase
    end

    assign o_num_hashes    = r_num_hashes;
    assign o_active_blocks = r_active_blocks;

endmodule

>>> hw/rtl/bbf_ctrl.sv
// controller state machine: clearing pass, accept, index, mask build, apply
// depends on bbf_pkg and blocked_bloom_filter_top_defines.svh
`include "blocked_bloom_filter_top_defines.svh"

module bbf_ctrl
    import bbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_INDEX = 5'b00100,
        S_MASK  = 5'b01000,
        S_APPLY = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_INDEX;
                end
            end
            S_INDEX: begin
                o_cmd.index_en = 1'b1;
                n_state        = S_MASK;
            end
            S_MASK: begin
                o_cmd.mask_step = 1'b1;
                if (i_status.mask_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!i_status.kind_check) begin
                    o_cmd.apply_wr = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // clearing runs once after reset only
    `BBF_ASSERT_NEXT(a_clear_once, r_state != S_CLEAR, r_state != S_CLEAR)
    `BBF_ASSERT_NEXT(a_index_to_mask, r_state == S_INDEX, r_state == S_MASK)

endmodule

>>> hw/rtl/bbf_dp.sv
// datapath: block select multiply, bit mask build, filter memory, result register
// depends on bbf_pkg and blocked_bloom_filter_top_defines.svh
`include "blocked_bloom_filter_top_defines.svh"

module bbf_dp
    import bbf_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [63:0]        i_s_tdata,
    input  logic               i_s_tuser,
    input  logic [NH_W-1:0]    i_num_hashes,
    input  logic [SCALE_W-1:0] i_active_blocks,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int IW = (AW > SCALE_W) ? AW : SCALE_W;

    logic [BLOCK_BITS-1:0] r_mem [NUM_BLOCKS];
    logic [BLOCK_BITS-1:0] r_rdata;
    logic [BLOCK_BITS-1:0] r_mask;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_idx;
    logic                  r_kind;
    logic [PROD_W-1:0]     r_prod_hi;
    logic [PROD_W-1:0]     r_prod_lo;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_step;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic                  r_present;

    logic [SCALE_W-1:0]    blk_scale;
    logic [PROD_W-1:0]     mid;
    logic [IW-1:0]         blk_w;
    logic [BLOCK_BITS-1:0] lane_mask;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_free;

    // clamp the block count to the store size
    always_comb begin
        if (17'(i_active_blocks) > 17'(NUM_BLOCKS)) begin
            blk_scale = SCALE_W'(NUM_BLOCKS);
        end else begin
            blk_scale = i_active_blocks;
        end
    end

    // high word of hash * scale, from the two registered half products
    assign mid   = r_prod_hi + PROD_W'(r_prod_lo[PROD_W-1:HALF_W]);
    assign blk_w = IW'(mid[PROD_W-1:HALF_W]);

    // eight bit positions per step, each pos + j*step mod 512
    always_comb begin
        logic [POS_W-1:0] lane_pos;
        lane_mask = '0;
        for (int j = 0; j < LANES; j++) begin
            lane_pos = r_pos + POS_W'(POS_W'(j) * r_step);
            if ((r_cnt + CNT_W'(j)) < CNT_W'(i_num_hashes)) begin
                lane_mask = lane_mask | (BLOCK_BITS'(1) << lane_pos);
            end
        end
    end

    assign cnt_next = r_cnt + CNT_W'(LANES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_s_tuser;
            r_prod_hi <= PROD_W'(i_s_tdata[63:HALF_W]) * PROD_W'(blk_scale);
            r_prod_lo <= PROD_W'(i_s_tdata[HALF_W-1:0]) * PROD_W'(blk_scale);
            r_pos     <= i_s_tdata[HALF_W+POS_W-1:HALF_W];
            r_step    <= i_s_tdata[POS_W-1:0];
            r_cnt     <= '0;
            r_mask    <= '0;
        end else if (i_cmd.mask_step) begin
            r_pos  <= r_pos + POS_W'(r_step * POS_W'(LANES));
            r_cnt  <= cnt_next;
            r_mask <= r_mask | lane_mask;
        end
        if (i_cmd.index_en) begin
            r_idx <= blk_w[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // filter store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.apply_wr) begin
            r_mem[r_idx] <= r_rdata | r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx];
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_present <= ((r_rdata & r_mask) == r_mask);
        end
    end

    assign o_status.clear_last = (r_clr == AW'(NUM_BLOCKS - 1));
    assign o_status.mask_done  = (CNT_W'(i_num_hashes) <= cnt_next);
    assign o_status.kind_check = (r_kind == KIND_CHECK);
    assign o_status.out_free   = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_present};

    `BBF_ASSERT_IMP(a_load_is_check, i_cmd.load_out, r_kind == KIND_CHECK)
    `BBF_ASSERT_IMP(a_write_is_insert, i_cmd.apply_wr, r_kind == KIND_INSERT)
    `BBF_ASSERT_NEXT(a_zero_k_present, i_cmd.load_out && (i_num_hashes == '0), r_present)

endmodule

>>> hw/rtl/blocked_bloom_filter_top.sv
// Blocked bloom filter over 512-bit blocks. Each input transfer carries a 64-bit
// hash in tdata and the kind in tuser (0 insert, 1 check); a check gives one output
// transfer with present in tdata bit 0, an insert gives none. Items are handled one
// at a time by a read-modify-write of a single block. An accepted item passes
// through an index step, mask steps that each add eight bit positions and an apply
// step, in which the block is written or the result is loaded; only then is the
// next item accepted. A check holds in its apply step while an earlier result still
// sits unaccepted in the output register. After reset a clearing pass writes zero
// to the NUM_BLOCKS rows of the filter memory, one row a cycle, and s_tready stays
// low until it ends; apb writes are taken throughout. A finished result waits in
// an output register, and the block moves on to the next item while it waits
// there.
// depends on bbf_pkg, bbf_regs, bbf_ctrl and bbf_dp
module blocked_bloom_filter_top
    import bbf_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] hash
    input  logic        i_s_tuser,   // [0] kind
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] present, [7:1] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [NH_W-1:0]    num_hashes;
    logic [SCALE_W-1:0] active_blocks;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    bbf_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_num_hashes    (num_hashes),
        .o_active_blocks (active_blocks)
    );

    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bbf_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_num_hashes    (num_hashes),
        .i_active_blocks (active_blocks),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata)
    );

endmodule

>>> verif/tb_top.sv
// self-checking testbench for blocked_bloom_filter_top: stream driver and monitor,
// apb register writes between phases and an in-bench filter predictor
// depends on bbf_pkg and the blocked_bloom_filter_top rtl
module tb_top
    import bbf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS   = 1024;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HISTORY_MAX  = 256;
    localparam int IDLE_PCT     = 20;

    typedef struct packed {
        logic        kind;
        logic [63:0] hash;
    } t_bloom_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [63:0] hash
    logic        i_s_tuser;   // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [0] present, [7:1] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [BLOCK_BITS-1:0] filter_rows [NUM_BLOCKS];
    logic [NH_W-1:0]       cfg_hashes;
    logic [SCALE_W-1:0]    cfg_blocks;

    t_bloom_op   hash_ops_q [$];
    logic        presence_q [$];
    logic [63:0] inserted_q [$];
    t_bloom_op   next_op;
    logic        calm;
    int          error_count;
    int          cycle_count;

    blocked_bloom_filter_top #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // insert sets the k positions of the chosen block, check reports whether all are set
    function automatic logic filter_apply(input logic kind, input logic [63:0] hash);
        logic [127:0] prod;
        logic [11:0]  span;
        int unsigned  row;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  acc;
        logic         all_set;
        span = (cfg_blocks > NUM_BLOCKS) ? 12'(NUM_BLOCKS) : {1'b0, cfg_blocks};
        prod = {64'd0, hash} * {116'd0, span};
        // the block index is below the clamped block count, so 32 bits hold it
        row = prod[95:64];
        if (row >= NUM_BLOCKS)
            row = NUM_BLOCKS - 1;
        lo = {32'd0, hash[31:0]};
        hi = {32'd0, hash[63:32]};
        all_set = 1'b1;
        for (int i = 0; i < cfg_hashes; i++) begin
            acc = lo * 64'(i) + hi;
            if (kind == KIND_INSERT)
                filter_rows[row][acc[POS_W-1:0]] = 1'b1;
            else if (!filter_rows[row][acc[POS_W-1:0]])
                all_set = 1'b0;
        end
        return all_set;
    endfunction

    // stream driver; predicts each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (i_s_tuser == KIND_CHECK)
                    presence_q.push_back(filter_apply(i_s_tuser, i_s_tdata));
                else
                    void'(filter_apply(i_s_tuser, i_s_tdata));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (hash_ops_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_op = hash_ops_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= next_op.hash;
                    i_s_tuser  <= next_op.kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (presence_q.size() == 0) begin
                    $display("%0t: unexpected result transfer: expected none, actual tdata %h",
                             $realtime, o_m_tdata);
                    error_count++;
                end else if (o_m_tdata !== {7'd0, presence_q[0]}) begin
                    $display("%0t: present mismatch: expected %h, actual %h",
                             $realtime, {7'd0, presence_q[0]}, o_m_tdata);
                    error_count++;
                    void'(presence_q.pop_front());
                end else begin
                    void'(presence_q.pop_front());
                end
            end
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d ops and %0d results outstanding",
                     $realtime, hash_ops_q.size(), presence_q.size());
            $display("FAIL blocked_bloom_filter_top");
            $finish;
        end
    end

    // apb write, then a read back of the same register
    task automatic apb_write_reg(input logic reg_index, input logic [31:0] value);
        logic [31:0] mask;
        mask = (reg_index == REG_NUM_HASHES) ? 32'h7F : 32'h7FF;
        for (int rd = 0; rd < 2; rd++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (rd == 0);
            paddr   <= {reg_index, 2'b00};
            pwdata  <= value;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready)
                @(posedge i_clk);
            if (rd == 0) begin
                if (reg_index == REG_NUM_HASHES)
                    cfg_hashes = value[NH_W-1:0];
                else
                    cfg_blocks = value[SCALE_W-1:0];
            end else if ((prdata & mask) !== (value & mask)) begin
                $display("%0t: register %0d read back: expected %h, actual %h",
                         $realtime, reg_index, value & mask, prdata & mask);
                error_count++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // wait until every op is accepted and every result has arrived, then let the pipe empty
    task automatic settle_filter();
        while (hash_ops_q.size() != 0 || i_s_tvalid || presence_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_op(input logic kind, input logic [63:0] hash);
        hash_ops_q.push_back('{kind: kind, hash: hash});
    endtask

    // inserts and checks of earlier inserts, plus checks of fresh hashes
    task automatic push_random_ops(input int count);
        int          roll;
        logic [63:0] h;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            h = {$urandom, $urandom};
            if (roll < 45) begin
                case ($urandom_range(0, 9))
                    0: h[63:32] = 32'd0;
                    1: h[31:0]  = 32'd0;
                    2: h[31:0]  = 32'hFFFFFFFF;
                    default: ;
                endcase
                push_op(KIND_INSERT, h);
                inserted_q.push_back(h);
                if (inserted_q.size() > HISTORY_MAX)
                    void'(inserted_q.pop_front());
            end else if (roll < 85 && inserted_q.size() != 0) begin
                push_op(KIND_CHECK, inserted_q[$urandom_range(0, inserted_q.size() - 1)]);
            end else begin
                push_op(KIND_CHECK, h);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] hashes, input logic [31:0] blocks,
                             input int count);
        settle_filter();
        apb_write_reg(REG_NUM_HASHES, hashes);
        apb_write_reg(REG_ACTIVE_BLOCKS, blocks);
        push_random_ops(count);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = KIND_INSERT;
        i_m_tready  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        error_count = 0;
        cycle_count = 0;
        cfg_hashes  = NUM_HASHES_RST;
        cfg_blocks  = ACTIVE_BLOCKS_RST;
        for (int r = 0; r < NUM_BLOCKS; r++)
            filter_rows[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty filter, extreme hash values
        push_op(KIND_CHECK,  64'h0);
        push_op(KIND_INSERT, 64'h0);
        push_op(KIND_CHECK,  64'h0);
        push_op(KIND_INSERT, 64'hFFFFFFFF_FFFFFFFF);
        push_op(KIND_CHECK,  64'hFFFFFFFF_FFFFFFFF);
        push_op(KIND_CHECK,  64'hFFFFFFFF_00000000);
        push_op(KIND_INSERT, 64'h00000000_FFFFFFFF);
        push_op(KIND_CHECK,  64'h00000000_FFFFFFFF);
        push_op(KIND_CHECK,  64'h80000000_00000000);
        push_op(KIND_INSERT, 64'h80000000_00000000);
        push_op(KIND_CHECK,  64'h80000000_00000000);
        push_random_ops(200);

        // zero hashes: inserts change nothing, checks always present
        settle_filter();
        apb_write_reg(REG_NUM_HASHES, 32'd0);
        push_op(KIND_CHECK,  64'h12345678_9ABCDEF0);
        push_op(KIND_INSERT, 64'h0F0F0F0F_F0F0F0F0);
        push_random_ops(150);

        // more than 64 hashes with too many blocks, clamped to the store
        settle_filter();
        apb_write_reg(REG_NUM_HASHES, 32'd127);
        apb_write_reg(REG_ACTIVE_BLOCKS, 32'd2047);
        push_op(KIND_CHECK,  64'hFFFFFFFF_FFFFFFFF);
        push_op(KIND_INSERT, 64'hFFFFFFFF_FFFFFFFF);
        push_op(KIND_CHECK,  64'hFFFFFFFF_FFFFFFFF);
        push_random_ops(200);

        // zero blocks: everything lands in block 0
        settle_filter();
        apb_write_reg(REG_NUM_HASHES, 32'd8);
        apb_write_reg(REG_ACTIVE_BLOCKS, 32'd0);
        push_op(KIND_INSERT, 64'hFFFFFFFF_FFFFFFFF);
        push_op(KIND_CHECK,  64'h0);
        push_random_ops(200);

        run_phase(32'd64, 32'd1, 200);

        calm <= 1'b1;
        run_phase(32'd3, 32'd1024, 250);
        settle_filter();
        calm <= 1'b0;

        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(1, 24),
                      ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 2047),
                      200);

        settle_filter();
        if (error_count == 0) begin
            $display("PASS blocked_bloom_filter_top");
        end else begin
            $display("FAIL blocked_bloom_filter_top");
        end
        $finish;
    end

endmodule
